// ===== src/vtv_pkg.sv =====
package vtv_pkg;

   localparam int CoordWidth = 32;
   localparam int CfgWidth = 31;
   localparam int CoeffCount = 16;
   localparam int CoeffIdxWidth = 4;
   localparam int CsrIdxWidth = 2;

   typedef enum logic [0:0] {
      ACT_LOAD = 1'b0,
      ACT_VERTEX = 1'b1
   } action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_HALF_WIDTH = 2'd2,
      CSR_HALF_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      logic last;
   } vertex_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      logic w_zero;
      logic ovf;
      logic last;
   } result_type;

   typedef struct packed {
      logic [CfgWidth-1:0] center_x;
      logic [CfgWidth-1:0] center_y;
      logic [CfgWidth-1:0] half_width;
      logic [CfgWidth-1:0] half_height;
   } viewport_type;

   function automatic logic signed [CoordWidth-1:0] sat_fn(
      input logic signed [95:0] v,
      output logic ovf
   );
      logic signed [95:0] max_v;
      logic signed [95:0] min_v;
      max_v = 96'sd2147483647;
      min_v = -96'sd2147483648;
      ovf = 1'b0;
      if (v > max_v) begin
         ovf = 1'b1;
         sat_fn = 32'sh7fffffff;
      end else if (v < min_v) begin
         ovf = 1'b1;
         sat_fn = 32'sh80000000;
      end else begin
         sat_fn = v[CoordWidth-1:0];
      end
   endfunction

endpackage

// ===== src/vtv_divider.sv =====
module vtv_divider import vtv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic in_valid,
   input logic signed [CoordWidth-1:0] in_num,
   input logic signed [CoordWidth-1:0] in_den,
   input logic in_advance,
   output logic signed [CoordWidth-1:0] out_quot,
   output logic out_ovf
);
   localparam int NumWidth = CoordWidth + FRAC_BITS;
   localparam int Steps = NumWidth;

   logic [NumWidth-1:0] rem_ff [Steps+1];
   logic [NumWidth-1:0] quo_ff [Steps+1];
   logic [CoordWidth-1:0] den_ff [Steps+1];
   logic neg_ff [Steps+1];
   logic [NumWidth-1:0] rem_in [Steps+1];
   logic [NumWidth-1:0] quo_in [Steps+1];
   logic signed [95:0] signed_q;
   logic [NumWidth:0] quo_ext;

   always_comb begin
      logic [NumWidth-1:0] num_mag;
      logic [NumWidth-1:0] num_ext;
      num_ext = {{(NumWidth-CoordWidth){in_num[CoordWidth-1]}}, in_num} <<< FRAC_BITS;
      num_mag = in_num[CoordWidth-1] ? (~num_ext + 1'b1) : num_ext;
      rem_in[0] = '0;
      quo_in[0] = num_mag;
      for (int s = 1; s <= Steps; s++) begin
         logic [NumWidth:0] trial;
         logic [NumWidth-1:0] shifted;
         shifted = {rem_ff[s-1][NumWidth-2:0], quo_ff[s-1][NumWidth-1]};
         trial = {1'b0, shifted} - {{(NumWidth-CoordWidth+1){1'b0}}, den_ff[s-1]};
         if (!trial[NumWidth] || rem_ff[s-1][NumWidth-1]) begin
            rem_in[s] = trial[NumWidth-1:0];
            quo_in[s] = {quo_ff[s-1][NumWidth-2:0], 1'b1};
         end else begin
            rem_in[s] = shifted;
            quo_in[s] = {quo_ff[s-1][NumWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= in_den[CoordWidth-1] ? -in_den : in_den;
         neg_ff[0] <= (in_num[CoordWidth-1] ^ in_den[CoordWidth-1]) && in_valid;
         for (int s = 1; s <= Steps; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   always_comb begin
      quo_ext = {1'b0, quo_ff[Steps]};
      signed_q = neg_ff[Steps] ? -$signed({{(95-NumWidth){1'b0}}, quo_ext})
                               : $signed({{(95-NumWidth){1'b0}}, quo_ext});
      out_quot = sat_fn(signed_q, out_ovf);
   end
endmodule

// ===== src/vtv_front.sv =====
module vtv_front import vtv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic in_action,
   input logic [CoeffIdxWidth-1:0] in_idx,
   input logic signed [CoordWidth-1:0] in_coeff,
   input vertex_type in_vertex,
   output logic q_valid,
   input logic q_ready,
   output logic signed [CoordWidth-1:0] q_clip [4],
   output logic q_ovf,
   output logic q_last
);
   logic signed [CoordWidth-1:0] coeff_ff [CoeffCount];
   logic signed [63:0] prod_ff [4][3];
   logic signed [CoordWidth-1:0] trans_ff [4];
   logic s1_valid_ff, s2_valid_ff, s1_last_ff, s2_last_ff;
   logic signed [CoordWidth-1:0] clip_ff [4];
   logic ovf_ff;
   logic advance;
   logic signed [CoordWidth-1:0] clip_in [4];
   logic ovf_in;

   assign advance = !s2_valid_ff || q_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready && in_action == ACT_LOAD) begin
         coeff_ff[in_idx] <= in_coeff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid && in_action == ACT_VERTEX;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            prod_ff[r][0] <= coeff_ff[r*4] * in_vertex.x;
            prod_ff[r][1] <= coeff_ff[r*4+1] * in_vertex.y;
            prod_ff[r][2] <= coeff_ff[r*4+2] * in_vertex.z;
            trans_ff[r] <= coeff_ff[r*4+3];
         end
         s1_last_ff <= in_vertex.last;
         clip_ff <= clip_in;
         ovf_ff <= ovf_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      logic o;
      logic signed [95:0] sum;
      ovf_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         sum = 96'(prod_ff[r][0] >>> FRAC_BITS) + 96'(prod_ff[r][1] >>> FRAC_BITS)
             + 96'(prod_ff[r][2] >>> FRAC_BITS) + 96'(trans_ff[r]);
         clip_in[r] = sat_fn(sum, o);
         ovf_in = ovf_in | o;
      end
   end

   assign q_valid = s2_valid_ff;
   assign q_clip = clip_ff;
   assign q_ovf = ovf_ff;
   assign q_last = s2_last_ff;
endmodule

// ===== src/vtv_back.sv =====
module vtv_back import vtv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic signed [CoordWidth-1:0] in_clip [4],
   input logic in_ovf,
   input logic in_last,
   input viewport_type vp,
   output logic out_valid,
   input logic out_ready,
   output result_type out_data
);
   localparam int DivLat = CoordWidth + FRAC_BITS + 1;

   logic [DivLat-1:0] v_ff;
   logic [DivLat-1:0] wz_ff, ovf_ff, last_ff;
   logic signed [CoordWidth-1:0] cx_ff [DivLat];
   logic signed [CoordWidth-1:0] cy_ff [DivLat];
   logic signed [CoordWidth-1:0] cz_ff [DivLat];
   logic signed [CoordWidth-1:0] qx, qy, qz;
   logic ox, oy, oz;
   logic signed [CoordWidth-1:0] dx_ff, dy_ff, dz_ff;
   logic d_valid_ff, d_wz_ff, d_ovf_ff, d_last_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [CoordWidth-1:0] pz_ff;
   logic p_valid_ff, p_ovf_ff, p_wz_ff, p_last_ff;
   logic [CfgWidth-1:0] pcx_ff, pcy_ff;
   logic o_valid_ff;
   result_type o_ff, o_in;
   logic advance, wz;

   assign advance = !o_valid_ff || out_ready;
   assign in_ready = advance;
   assign wz = in_clip[3] == '0;

   vtv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (.clock, .in_valid,
      .in_num(in_clip[0]), .in_den(in_clip[3]), .in_advance(advance),
      .out_quot(qx), .out_ovf(ox));
   vtv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (.clock, .in_valid,
      .in_num(in_clip[1]), .in_den(in_clip[3]), .in_advance(advance),
      .out_quot(qy), .out_ovf(oy));
   vtv_divider #(.FRAC_BITS(FRAC_BITS)) u_div_z (.clock, .in_valid,
      .in_num(in_clip[2]), .in_den(in_clip[3]), .in_advance(advance),
      .out_quot(qz), .out_ovf(oz));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= {v_ff[DivLat-2:0], in_valid};
         d_valid_ff <= v_ff[DivLat-1];
         p_valid_ff <= d_valid_ff;
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wz_ff <= {wz_ff[DivLat-2:0], wz};
         ovf_ff <= {ovf_ff[DivLat-2:0], in_ovf};
         last_ff <= {last_ff[DivLat-2:0], in_last};
         cx_ff[0] <= in_clip[0];
         cy_ff[0] <= in_clip[1];
         cz_ff[0] <= in_clip[2];
         for (int s = 1; s < DivLat; s++) begin
            cx_ff[s] <= cx_ff[s-1];
            cy_ff[s] <= cy_ff[s-1];
            cz_ff[s] <= cz_ff[s-1];
         end
         if (wz_ff[DivLat-1]) begin
            dx_ff <= cx_ff[DivLat-1];
            dy_ff <= cy_ff[DivLat-1];
            dz_ff <= cz_ff[DivLat-1];
            d_ovf_ff <= ovf_ff[DivLat-1];
         end else begin
            dx_ff <= qx;
            dy_ff <= qy;
            dz_ff <= qz;
            d_ovf_ff <= ovf_ff[DivLat-1] | ox | oy | oz;
         end
         d_wz_ff <= wz_ff[DivLat-1];
         d_last_ff <= last_ff[DivLat-1];
         px_ff <= dx_ff * $signed({1'b0, vp.half_width});
         py_ff <= dy_ff * $signed({1'b0, vp.half_height});
         pcx_ff <= vp.center_x;
         pcy_ff <= vp.center_y;
         pz_ff <= dz_ff;
         p_wz_ff <= d_wz_ff;
         p_ovf_ff <= d_ovf_ff;
         p_last_ff <= d_last_ff;
         o_ff <= o_in;
      end
   end

   always_comb begin
      logic o1, o2;
      o_in.x = sat_fn(96'($signed({1'b0, pcx_ff})) + 96'(px_ff >>> FRAC_BITS), o1);
      o_in.y = sat_fn(96'($signed({1'b0, pcy_ff})) - 96'(py_ff >>> FRAC_BITS), o2);
      o_in.z = pz_ff;
      o_in.w_zero = p_wz_ff;
      o_in.ovf = p_ovf_ff | o1 | o2;
      o_in.last = p_last_ff;
   end

   assign out_valid = o_valid_ff;
   assign out_data = o_ff;
endmodule

// ===== src/vertex_transform_viewport_top.sv =====
// Throughput: one transaction per cycle while the result stream is not stalled by
// rsp_tready; the divide is a fully pipelined restoring array.
// Coefficient loads produce no result.
// Reset is synchronous, active high, and restores the viewport registers.
// Matrix coefficients are not reset and must be loaded before use.
module vertex_transform_viewport_top import vtv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // coeff_index, coeff_value, vertex_x, vertex_y, vertex_z, pad
   input logic [135:0] req_tdata,
   // action
   input logic req_tuser,
   input logic req_tlast,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // screen_x, screen_y, screen_z
   output logic [95:0] rsp_tdata,
   // w_was_zero, overflowed
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CsrIdxWidth-1:0] csr_index,
   input logic [CfgWidth-1:0] csr_data
);
   viewport_type vp_ff;
   vertex_type vtx;
   logic q_valid, q_ready, q_ovf, q_last;
   logic signed [CoordWidth-1:0] q_clip [4];
   result_type rsp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff.center_x <= 31'd26214400;
         vp_ff.center_y <= 31'd15728640;
         vp_ff.half_width <= 31'd26214400;
         vp_ff.half_height <= 31'd15728640;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X: vp_ff.center_x <= csr_data;
            CSR_CENTER_Y: vp_ff.center_y <= csr_data;
            CSR_HALF_WIDTH: vp_ff.half_width <= csr_data;
            CSR_HALF_HEIGHT: vp_ff.half_height <= csr_data;
            default: ;
         endcase
      end
   end

   assign vtx.x = req_tdata[67:36];
   assign vtx.y = req_tdata[99:68];
   assign vtx.z = req_tdata[131:100];
   assign vtx.last = req_tlast;

   vtv_front #(.FRAC_BITS(FRAC_BITS)) u_front (.clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_action(req_tuser),
      .in_idx(req_tdata[3:0]), .in_coeff(req_tdata[35:4]), .in_vertex(vtx),
      .q_valid, .q_ready, .q_clip, .q_ovf, .q_last);

   vtv_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_clip(q_clip), .in_ovf(q_ovf),
      .in_last(q_last), .vp(vp_ff), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_data(rsp));

   assign rsp_tdata = {rsp.z, rsp.y, rsp.x};
   assign rsp_tuser = {rsp.ovf, rsp.w_zero};
   assign rsp_tlast = rsp.last;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_data_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");
endmodule

// ===== tb/vtv_screen_checker.sv =====
`timescale 1ns / 100ps

module vtv_screen_checker import vtv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [135:0] req_tdata,
   input logic req_tuser,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic rsp_tlast,
   input logic csr_valid,
   input logic csr_ready,
   input logic [CsrIdxWidth-1:0] csr_index,
   input logic [CfgWidth-1:0] csr_data,
   output int mismatch_count,
   output int points_pending
);

   typedef struct {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic w_zero;
      logic ovf;
      logic last;
   } screen_point_type;

   screen_point_type expected_points[$];
   longint mvp_coeffs[CoeffCount];
   longint view_center_x, view_center_y, view_half_w, view_half_h;

   function automatic longint clamp32(longint v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic screen_point_type project_vertex(logic [135:0] d, logic last);
      longint coord[3];
      longint clip[4];
      longint s;
      logic ovf;
      screen_point_type p;
      coord[0] = longint'($signed(d[67:36]));
      coord[1] = longint'($signed(d[99:68]));
      coord[2] = longint'($signed(d[131:100]));
      ovf = 1'b0;
      for (int r = 0; r < 4; r++) begin
         s = mvp_coeffs[r*4+3];
         for (int c = 0; c < 3; c++) begin
            s += (mvp_coeffs[r*4+c] * coord[c]) >>> FRAC_BITS;
         end
         clip[r] = clamp32(s, ovf);
      end
      p.w_zero = (clip[3] == 0);
      if (!p.w_zero) begin
         for (int c = 0; c < 3; c++) begin
            clip[c] = clamp32((clip[c] * (64'sd1 <<< FRAC_BITS)) / clip[3], ovf);
         end
      end
      p.sx = 32'(clamp32(view_center_x + ((clip[0] * view_half_w) >>> FRAC_BITS), ovf));
      p.sy = 32'(clamp32(view_center_y - ((clip[1] * view_half_h) >>> FRAC_BITS), ovf));
      p.sz = 32'(clip[2]);
      p.ovf = ovf;
      p.last = last;
      return p;
   endfunction

   always @(posedge clock) begin
      screen_point_type want;
      screen_point_type got;
      if (reset) begin
         view_center_x = 26214400;
         view_center_y = 15728640;
         view_half_w = 26214400;
         view_half_h = 15728640;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CENTER_X: view_center_x = longint'(csr_data);
               CSR_CENTER_Y: view_center_y = longint'(csr_data);
               CSR_HALF_WIDTH: view_half_w = longint'(csr_data);
               CSR_HALF_HEIGHT: view_half_h = longint'(csr_data);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sx = rsp_tdata[31:0];
            got.sy = rsp_tdata[63:32];
            got.sz = rsp_tdata[95:64];
            got.w_zero = rsp_tuser[0];
            got.ovf = rsp_tuser[1];
            got.last = rsp_tlast;
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected result transaction: x=%h y=%h z=%h",
                     got.sx, got.sy, got.sz);
               end
            end else begin
               want = expected_points.pop_front();
               if (got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz
                     || got.w_zero !== want.w_zero || got.ovf !== want.ovf
                     || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch expected x=%h y=%h z=%h wz=%b ovf=%b last=%b",
                        want.sx, want.sy, want.sz, want.w_zero, want.ovf, want.last);
                     $display("         actual   x=%h y=%h z=%h wz=%b ovf=%b last=%b",
                        got.sx, got.sy, got.sz, got.w_zero, got.ovf, got.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser) == ACT_LOAD) begin
               mvp_coeffs[req_tdata[3:0]] = longint'($signed(req_tdata[35:4]));
            end else begin
               expected_points.push_back(project_vertex(req_tdata, req_tlast));
            end
         end
      end
      points_pending = expected_points.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import vtv_pkg::*;

   localparam int FracBits = 16;
   localparam int Latency = FracBits + 37;
   localparam int CycleLimit = 400000;
   localparam logic [31:0] QOne = 32'h0001_0000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [135:0] req_tdata;
   logic req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0] csr_data;
   int mismatch_count;
   int points_pending;
   int cycle_count;
   logic quiet_mode;
   logic hold_output;
   bit hold_done;

   vertex_transform_viewport_top #(.FRAC_BITS(FracBits)) i_dut (.*);

   vtv_screen_checker #(.FRAC_BITS(FracBits)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("vertex_transform_viewport_top regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output && !hold_done) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic logic [31:0] random_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      endcase
   endfunction

   task automatic send_item(action_type act, logic [3:0] idx, logic [31:0] cval,
         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic last, logic gaps);
      int gap;
      gap = 0;
      if (gaps && !quiet_mode && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {4'b0, vz, vy, vx, cval, idx};
      req_tuser = act;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_coeff(logic [3:0] idx, logic [31:0] v, logic gaps);
      send_item(ACT_LOAD, idx, v, $urandom, $urandom, $urandom, 1'($urandom), gaps);
   endtask

   task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
         logic last, logic gaps);
      send_item(ACT_VERTEX, 4'($urandom), $urandom, vx, vy, vz, last, gaps);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (points_pending != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_viewport(csr_index_type idx, logic [CfgWidth-1:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_viewport(logic [CfgWidth-1:0] cx, logic [CfgWidth-1:0] cy,
         logic [CfgWidth-1:0] hw, logic [CfgWidth-1:0] hh);
      write_viewport(CSR_CENTER_X, cx);
      write_viewport(CSR_CENTER_Y, cy);
      write_viewport(CSR_HALF_WIDTH, hw);
      write_viewport(CSR_HALF_HEIGHT, hh);
   endtask

   task automatic random_stream(int count, logic gaps);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 6) == 0) begin
            load_coeff(4'($urandom), random_q(), gaps);
         end else begin
            send_vertex(random_q(), random_q(), random_q(), $urandom_range(0, 7) == 0,
               gaps);
         end
      end
   endtask

   initial begin
      quiet_mode = 1'b0;
      hold_output = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_LOAD;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 16; i++) begin
         load_coeff(4'(i), (i % 5 == 0) ? QOne : 32'h0, 1'b1);
      end
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0, 1'b1);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b1);
      send_vertex(QOne, 32'hfffe_0000, 32'h0003_0000, 1'b1, 1'b1);
      load_coeff(4'd15, 32'h0, 1'b1);
      send_vertex(32'h0002_8000, 32'h0001_0000, 32'h0000_4000, 1'b1, 1'b1);
      load_coeff(4'd14, 32'h0000_0100, 1'b1);
      send_vertex(32'h0000_0010, 32'h0, 32'h0100_0000, 1'b0, 1'b1);
      drain_pipeline();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_viewport(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
            1: set_viewport('1, '1, '1, '1);
            2: set_viewport('0, '0, '0, '0);
            3: set_viewport(31'($urandom_range(0, 32'h0400_0000)),
                  31'($urandom_range(0, 32'h0400_0000)), 31'd26214400, 31'd15728640);
            default: set_viewport(31'd26214400, 31'd15728640, 31'd26214400,
                  31'd15728640);
         endcase
         for (int i = 0; i < 16; i++) load_coeff(4'(i), random_q(), 1'b1);
         if (phase == 2) begin
            hold_output = 1'b1;
            random_stream(100, 1'b0);
         end
         if (phase == 4) quiet_mode = 1'b1;
         random_stream(50, 1'b1);
         drain_pipeline();
      end

      if (mismatch_count == 0 && points_pending == 0) begin
         $display("vertex_transform_viewport_top regression: pass");
      end else begin
         $display("vertex_transform_viewport_top regression: fail");
      end
      $finish;
   end

endmodule
